@@ sv/config_bitstream_command_parser_macros.svh @@
// Assertion macros for the configuration bitstream command parser.
`ifndef CONFIG_BITSTREAM_COMMAND_PARSER_MACROS_SVH
`define CONFIG_BITSTREAM_COMMAND_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CBCP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cbcp assertion failed");
// Next-cycle implication.
`define CBCP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cbcp assertion failed");
`else
`define CBCP_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CBCP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ sv/cbcp_pkg.sv @@
// Types, codes and helper functions for the configuration bitstream command parser.
package cbcp_pkg;

    typedef enum logic [3:0] {
        PH_OPC, PH_LENH, PH_LENL, PH_HC0, PH_HC1, PH_PAY, PH_DC0, PH_DC1, PH_SKIP
    } phase_t;

    localparam logic [7:0] OP_PLL     = 8'hc1;
    localparam logic [7:0] OP_CFGMODE = 8'hc2;
    localparam logic [7:0] OP_FLASH   = 8'hc5;
    localparam logic [7:0] OP_LXLYS   = 8'hc8;
    localparam logic [7:0] OP_ACLCU   = 8'hc9;
    localparam logic [7:0] OP_DLCU    = 8'hca;
    localparam logic [7:0] OP_RXRYS   = 8'hce;
    localparam logic [7:0] OP_FRAM    = 8'hd2;
    localparam logic [7:0] OP_PATH    = 8'hd9;
    localparam logic [7:0] OP_CHG     = 8'hdb;
    localparam logic [7:0] OP_SPLL    = 8'hdd;
    localparam logic [7:0] OP_SLAVE   = 8'hde;

    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_COMMIT  = 2'd1;
    localparam logic [1:0] EV_ERROR   = 2'd2;

    localparam logic [2:0] TGT_TILE    = 3'd0;
    localparam logic [2:0] TGT_RAM_CFG = 3'd1;
    localparam logic [2:0] TGT_RAM_DAT = 3'd2;
    localparam logic [2:0] TGT_PLL     = 3'd3;
    localparam logic [2:0] TGT_NONE    = 3'd4;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_CRC  = 3'd1;
    localparam logic [2:0] ERR_LEN  = 3'd2;
    localparam logic [2:0] ERR_X    = 3'd3;
    localparam logic [2:0] ERR_Y    = 3'd4;
    localparam logic [2:0] ERR_CMD  = 3'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;  // reflected 0x1021

    localparam logic [7:0] TILE_X_MAX = 8'd81;
    localparam logic [7:0] TILE_Y_MAX = 8'd65;
    localparam logic [7:0] RAM_X_MAX  = 8'd3;
    localparam logic [7:0] RAM_Y_MAX  = 8'd7;
    localparam logic [15:0] RAM_DLCU_MAX = 16'd27;

    localparam int MAX_FRAM_LEN_DEF = 5120;
    localparam int MAX_TILE_LEN_DEF = 112;

    localparam int OUT_W = 80;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [2:0] target_of(input logic [7:0] opc, input logic ram_mode);
        case (opc)
            OP_DLCU: return ram_mode ? TGT_RAM_CFG : TGT_TILE;
            OP_FRAM: return TGT_RAM_DAT;
            OP_PLL:  return TGT_PLL;
            default: return TGT_NONE;
        endcase
    endfunction

    function automatic logic [3:0] skip_count(input logic [7:0] opc);
        case (opc) inside
            OP_PATH, OP_CHG:    return 4'd9;
            OP_PLL:             return 4'd6;
            OP_SLAVE, OP_CFGMODE: return 4'd3;
            default:            return 4'd0;
        endcase
    endfunction

endpackage

@@ sv/config_bitstream_command_parser.sv @@
// Configuration bitstream command parser: byte stream in, tagged payload/commit/error beats out.
//
//  channel | dir | tdata                         | tuser
//  s_      | in  | bitstream byte                | -
//  m_      | out | target, x, y, offset, byte,.. | event kind
//
// One byte per cycle: a beat is held in an input register, decoded, CRC-updated
// and written to the output register; a new beat is taken each cycle while the
// result side drains. The byte-wide CRC step sets the path length.
// After an error beat the parser halts: input beats are still taken but dropped
// until aresetn is pulled low. Reset is synchronous and clears all control state.
// A result waiting on m_tready stalls the input only while the held beat yields a result.
`include "config_bitstream_command_parser_macros.svh"

module config_bitstream_command_parser #(
    parameter int MAX_FRAM_LEN = cbcp_pkg::MAX_FRAM_LEN_DEF,
    parameter int MAX_TILE_LEN = cbcp_pkg::MAX_TILE_LEN_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] in_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [2:0] target_kind, [9:3] pos_x, [16:10] pos_y, [29:17] byte_offset,
    // [37:30] payload_byte, [40:38] error_code, [56:41] ram_address,
    // [64:57] pll_selected, [72:65] opcode_seen, [79:73] zero
    output logic [cbcp_pkg::OUT_W-1:0] m_tdata,
    output logic [1:0]                 m_tuser    // [1:0] event_kind
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // parser state
    cbcp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] crc_exp_reg, crc_exp_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic        ram_mode_reg, ram_mode_next;
    logic [6:0]  x_reg, x_next;
    logic [6:0]  y_reg, y_next;
    logic [7:0]  pll_reg, pll_next;
    logic [15:0] addr_reg, addr_next;
    logic        halted_reg, halted_next;

    // output register
    logic                       m_tvalid_reg;
    logic [cbcp_pkg::OUT_W-1:0] m_tdata_reg;
    logic [1:0]                 m_tuser_reg;

    logic        emit;
    logic [1:0]  ev_kind;
    logic [12:0] ev_off;
    logic [7:0]  ev_byte;
    logic [2:0]  ev_err;
    logic        fire, out_free, out_load;

    // shared decode
    logic [7:0]  b;
    logic [15:0] len_full;
    logic [2:0]  len_err;
    logic        crc_ok;
    logic [15:0] pay_count;
    logic [15:0] cnt_inc;
    logic        pos_op, pos_lx;
    logic        range_bad;
    logic [2:0]  tgt;

    // result checks
    logic        m_is_err;
    logic        m_fields_ok;

    assign b        = in_byte_reg;
    assign len_full = len_reg | {8'h00, b};
    assign crc_ok   = ({b, crc_low_reg} == crc_exp_reg);
    assign pay_count = (opcode_reg == cbcp_pkg::OP_SLAVE) ? 16'd1 : len_reg;
    assign cnt_inc  = cnt_reg + 16'd1;
    assign pos_lx   = (opcode_reg == cbcp_pkg::OP_LXLYS);
    assign pos_op   = pos_lx || (opcode_reg == cbcp_pkg::OP_RXRYS);
    assign tgt      = cbcp_pkg::target_of(opcode_reg, ram_mode_reg);

    always_comb begin
        if (cnt_reg == 16'd0) begin
            range_bad = b > (pos_lx ? cbcp_pkg::TILE_X_MAX : cbcp_pkg::RAM_X_MAX);
        end else begin
            range_bad = b > (pos_lx ? cbcp_pkg::TILE_Y_MAX : cbcp_pkg::RAM_Y_MAX);
        end
    end

    always_comb begin
        len_err = cbcp_pkg::ERR_NONE;
        unique case (opcode_reg) inside
            cbcp_pkg::OP_DLCU: begin
                if (len_full > (ram_mode_reg ? cbcp_pkg::RAM_DLCU_MAX : 16'(MAX_TILE_LEN)))
                    len_err = cbcp_pkg::ERR_LEN;
            end
            cbcp_pkg::OP_PATH, cbcp_pkg::OP_SPLL: begin
                if (len_full != 16'd1) len_err = cbcp_pkg::ERR_LEN;
            end
            cbcp_pkg::OP_PLL: begin
                if (len_full < 16'd12 || len_full > 16'd24) len_err = cbcp_pkg::ERR_LEN;
            end
            cbcp_pkg::OP_LXLYS, cbcp_pkg::OP_ACLCU, cbcp_pkg::OP_RXRYS: begin
                if (len_full != 16'd2) len_err = cbcp_pkg::ERR_LEN;
            end
            cbcp_pkg::OP_FRAM: begin
                if (len_full > 16'(MAX_FRAM_LEN)) len_err = cbcp_pkg::ERR_LEN;
            end
            cbcp_pkg::OP_CHG: begin
                if (len_full > 16'd12) len_err = cbcp_pkg::ERR_LEN;
            end
            cbcp_pkg::OP_SLAVE: begin
                if (len_full > 16'd1) len_err = cbcp_pkg::ERR_LEN;
            end
            cbcp_pkg::OP_FLASH: begin
                if (len_full > 16'd11) len_err = cbcp_pkg::ERR_LEN;
            end
            cbcp_pkg::OP_CFGMODE: begin
                if (len_full > 16'd20) len_err = cbcp_pkg::ERR_LEN;
            end
            default: len_err = cbcp_pkg::ERR_CMD;
        endcase
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (!halted_reg) begin
            unique case (phase_reg)
                cbcp_pkg::PH_OPC:
                    phase_next = (b == cbcp_pkg::OP_FRAM) ? cbcp_pkg::PH_LENH
                                                          : cbcp_pkg::PH_LENL;
                cbcp_pkg::PH_LENH: phase_next = cbcp_pkg::PH_LENL;
                cbcp_pkg::PH_LENL: begin
                    if (len_err == cbcp_pkg::ERR_NONE) phase_next = cbcp_pkg::PH_HC0;
                end
                cbcp_pkg::PH_HC0: phase_next = cbcp_pkg::PH_HC1;
                cbcp_pkg::PH_HC1: begin
                    if (crc_ok)
                        phase_next = (pay_count == 16'd0) ? cbcp_pkg::PH_DC0
                                                          : cbcp_pkg::PH_PAY;
                end
                cbcp_pkg::PH_PAY: begin
                    if (cnt_inc >= pay_count) phase_next = cbcp_pkg::PH_DC0;
                end
                cbcp_pkg::PH_DC0: phase_next = cbcp_pkg::PH_DC1;
                cbcp_pkg::PH_DC1: begin
                    if (crc_ok)
                        phase_next = (cbcp_pkg::skip_count(opcode_reg) == 4'd0)
                                   ? cbcp_pkg::PH_OPC : cbcp_pkg::PH_SKIP;
                end
                cbcp_pkg::PH_SKIP: begin
                    if (cnt_inc >= {12'h000, cbcp_pkg::skip_count(opcode_reg)})
                        phase_next = cbcp_pkg::PH_OPC;
                end
                default: phase_next = cbcp_pkg::PH_OPC;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        opcode_next   = opcode_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        crc_next      = cbcp_pkg::crc_byte(crc_reg, b);
        crc_exp_next  = crc_exp_reg;
        crc_low_next  = crc_low_reg;
        ram_mode_next = ram_mode_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        pll_next      = pll_reg;
        addr_next     = addr_reg;
        halted_next   = halted_reg;
        emit          = 1'b0;
        ev_kind       = cbcp_pkg::EV_PAYLOAD;
        ev_off        = 13'd0;
        ev_byte       = 8'd0;
        ev_err        = cbcp_pkg::ERR_NONE;
        if (halted_reg) begin
            crc_next = crc_reg;
        end else begin
            unique case (phase_reg) inside
                cbcp_pkg::PH_OPC: begin
                    crc_next    = cbcp_pkg::crc_byte(cbcp_pkg::CRC_INIT, b);
                    opcode_next = b;
                    len_next    = 16'd0;
                end
                cbcp_pkg::PH_LENH: len_next = {b, 8'h00};
                cbcp_pkg::PH_LENL: begin
                    len_next = len_full;
                    if (len_err != cbcp_pkg::ERR_NONE) begin
                        emit        = 1'b1;
                        ev_kind     = cbcp_pkg::EV_ERROR;
                        ev_err      = len_err;
                        halted_next = 1'b1;
                    end
                end
                cbcp_pkg::PH_HC0, cbcp_pkg::PH_DC0: begin
                    crc_exp_next = crc_reg ^ cbcp_pkg::CRC_INIT;
                    crc_low_next = b;
                end
                cbcp_pkg::PH_HC1: begin
                    if (!crc_ok) begin
                        emit        = 1'b1;
                        ev_kind     = cbcp_pkg::EV_ERROR;
                        ev_err      = cbcp_pkg::ERR_CRC;
                        halted_next = 1'b1;
                    end else begin
                        if (opcode_reg == cbcp_pkg::OP_LXLYS) ram_mode_next = 1'b0;
                        else if (opcode_reg == cbcp_pkg::OP_RXRYS) ram_mode_next = 1'b1;
                        cnt_next = 16'd0;
                    end
                end
                cbcp_pkg::PH_PAY: begin
                    cnt_next = cnt_inc;
                    if (tgt != cbcp_pkg::TGT_NONE) begin
                        emit    = 1'b1;
                        ev_off  = cnt_reg[12:0];
                        ev_byte = b;
                    end else if (opcode_reg == cbcp_pkg::OP_SPLL) begin
                        pll_next = b;
                    end else if (opcode_reg == cbcp_pkg::OP_ACLCU) begin
                        if (cnt_reg == 16'd0) addr_next = {b, addr_reg[7:0]};
                        else                  addr_next = {addr_reg[15:8], b};
                    end else if (pos_op) begin
                        if (range_bad) begin
                            emit        = 1'b1;
                            ev_kind     = cbcp_pkg::EV_ERROR;
                            ev_err      = (cnt_reg == 16'd0) ? cbcp_pkg::ERR_X
                                                             : cbcp_pkg::ERR_Y;
                            halted_next = 1'b1;
                        end else if (cnt_reg == 16'd0) begin
                            x_next = b[6:0];
                        end else begin
                            y_next = b[6:0];
                        end
                    end
                end
                cbcp_pkg::PH_DC1: begin
                    if (!crc_ok) begin
                        emit        = 1'b1;
                        ev_kind     = cbcp_pkg::EV_ERROR;
                        ev_err      = cbcp_pkg::ERR_CRC;
                        halted_next = 1'b1;
                    end else begin
                        cnt_next = 16'd0;
                        if (tgt != cbcp_pkg::TGT_NONE) begin
                            emit    = 1'b1;
                            ev_kind = cbcp_pkg::EV_COMMIT;
                        end
                    end
                end
                cbcp_pkg::PH_SKIP: cnt_next = cnt_inc;
                default: ;
            endcase
        end
    end

    // handshake: a beat that yields no result never waits on the output side
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = in_valid_reg && (out_free || !emit);
    assign out_load = fire && emit;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= cbcp_pkg::PH_OPC;
            opcode_reg   <= 8'd0;
            len_reg      <= 16'd0;
            cnt_reg      <= 16'd0;
            crc_reg      <= cbcp_pkg::CRC_INIT;
            crc_exp_reg  <= 16'd0;
            crc_low_reg  <= 8'd0;
            ram_mode_reg <= 1'b0;
            x_reg        <= 7'd0;
            y_reg        <= 7'd0;
            pll_reg      <= 8'h0f;
            addr_reg     <= 16'd0;
            halted_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            opcode_reg   <= opcode_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            crc_reg      <= crc_next;
            crc_exp_reg  <= crc_exp_next;
            crc_low_reg  <= crc_low_next;
            ram_mode_reg <= ram_mode_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            pll_reg      <= pll_next;
            addr_reg     <= addr_next;
            halted_reg   <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (out_load) begin
            m_tuser_reg <= ev_kind;
            m_tdata_reg <= {7'd0, opcode_reg, pll_reg, addr_reg, ev_err, ev_byte,
                            ev_off, y_reg, x_reg, tgt};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign m_is_err    = m_tvalid && (m_tuser == cbcp_pkg::EV_ERROR);
    assign m_fields_ok = (m_tdata[40:38] == cbcp_pkg::ERR_NONE)
                      && (m_tdata[2:0] != cbcp_pkg::TGT_NONE);

    `CBCP_ASSERT_IMPL(a_error_halts, aclk, aresetn, m_is_err, halted_reg)
    `CBCP_ASSERT_NEXT(a_halt_quiet, aclk, aresetn, halted_reg, !out_load && halted_reg)
    `CBCP_ASSERT_IMPL(a_ok_no_code, aclk, aresetn, m_tvalid && !m_is_err, m_fields_ok)

endmodule
